@@ rtl/rsut_pkg.sv @@
`timescale 1ns / 1ps

package rsut_pkg;

  // array and tree geometry
  localparam int MAX_ELEMENTS = 1024;
  localparam int TREE_NODES   = 2 * MAX_ELEMENTS;
  localparam int NODE_AW      = $clog2(TREE_NODES);
  localparam int LR_W         = NODE_AW + 1;

  // field widths
  localparam int IDX_W = 10;
  localparam int LEN_W = 11;
  localparam int VAL_W = 64;

  localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(1024);

  // command queue depth, power of two
  localparam int Q_DEPTH = 4;
  localparam int Q_PW    = $clog2(Q_DEPTH);

  // input action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic                    action;
    logic [IDX_W-1:0]        position;
    logic signed [VAL_W-1:0] new_value;
    logic [IDX_W-1:0]        range_low;
    logic [IDX_W-1:0]        range_high;
  } rsut_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] range_total;
    logic                    range_empty;
  } rsut_out_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_EMPTY = 2'd2
  } rsut_kind_t;

  // classified command handed from front to back
  typedef struct packed {
    rsut_kind_t       kind;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [VAL_W-1:0] value;
  } rsut_cmd_t;

endpackage

@@ rtl/range_sum_point_update_tree_top.sv @@
`timescale 1ns / 1ps

// channel  direction  payload              handshake
// cfg      in         active_length        cfg_valid / cfg_ready
// in       in         rsut_in_t beat       in_valid  / in_ready
// out      out        rsut_out_t beat      out_valid / out_ready
//
// after reset the node memory is zeroed one node a cycle, all 2048 nodes, in_ready low
// a write holds the back end for the leaf store, then one parent update per level
// a query holds it while it walks eleven levels, one read a cycle, with a left and a right
//   edge step per level, plus entry, final bound check and result load
// empty queries are answered from idle once the output is free, out-of-range writes are dropped at the input
// a 4-entry command queue lets inputs land while the tree walk or out_ready stalls

module range_sum_point_update_tree_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rsut_pkg::LEN_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rsut_pkg::rsut_in_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rsut_pkg::rsut_out_t        out_data
);
  import rsut_pkg::*;

  logic      q_full;
  logic      q_empty;
  logic      push;
  logic      pop;
  logic      back_busy;
  rsut_cmd_t push_data;
  rsut_cmd_t pop_data;

  rsut_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .back_busy (back_busy),
    .push      (push),
    .push_data (push_data)
  );

  rsut_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  rsut_back u_back (
    .clk       (clk),
    .rst       (rst),
    .busy      (back_busy),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/rsut_front.sv @@
`timescale 1ns / 1ps

module rsut_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rsut_pkg::LEN_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rsut_pkg::rsut_in_t        in_data,
  input  logic                      q_full,
  input  logic                      back_busy,
  output logic                      push,
  output rsut_pkg::rsut_cmd_t       push_data
);
  import rsut_pkg::*;

  logic [LEN_W-1:0] active_length;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] len_m1;
  logic [IDX_W-1:0] hi_clip;
  logic             keep;

  // length register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_length <= LENGTH_RESET;
    end else if (cfg_valid) begin
      active_length <= cfg_data;
    end
  end

  // effective length, oversized values saturate
  assign len_eff = (active_length > LEN_W'(MAX_ELEMENTS)) ? LEN_W'(MAX_ELEMENTS)
                                                          : active_length;
  assign len_m1  = len_eff - LEN_W'(1);

  // take beats while the tree is not clearing and the queue has room
  assign in_ready = !back_busy && !q_full;

  // classify the beat
  always_comb begin
    push_data.kind  = CMD_WRITE;
    push_data.idx_a = in_data.position;
    push_data.idx_b = in_data.range_high;
    push_data.value = in_data.new_value;
    hi_clip         = in_data.range_high;
    keep            = 1'b1;
    if (in_data.action == ACT_WRITE) begin
      // writes past the end are dropped
      keep = {1'b0, in_data.position} < len_eff;
    end else begin
      if ({1'b0, in_data.range_high} > len_m1) begin
        hi_clip = len_m1[IDX_W-1:0];
      end
      push_data.idx_a = in_data.range_low;
      push_data.idx_b = hi_clip;
      if (len_eff == '0 || {1'b0, in_data.range_low} >= len_eff ||
          in_data.range_low > hi_clip) begin
        push_data.kind = CMD_EMPTY;
      end else begin
        push_data.kind = CMD_QUERY;
      end
    end
  end

  assign push = in_valid && in_ready && keep;

endmodule

@@ rtl/rsut_fifo.sv @@
`timescale 1ns / 1ps

module rsut_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rsut_pkg::rsut_cmd_t push_data,
  output logic                full,
  input  logic                pop,
  output rsut_pkg::rsut_cmd_t pop_data,
  output logic                empty
);
  import rsut_pkg::*;

  rsut_cmd_t       slots [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr;
  logic [Q_PW-1:0] rd_ptr;
  logic [Q_PW:0]   count;

  assign full     = count == (Q_PW+1)'(Q_DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PW'(1);
      end
      if (push && !pop) begin
        count <= count + (Q_PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (Q_PW+1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("command queue underflow");
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_PW+1)'(Q_DEPTH))
    else $error("command queue fill level out of range");

endmodule

@@ rtl/rsut_back.sv @@
`timescale 1ns / 1ps

module rsut_back (
  input  logic                clk,
  input  logic                rst,
  output logic                busy,
  input  logic                q_empty,
  input  rsut_pkg::rsut_cmd_t q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output rsut_pkg::rsut_out_t out_data
);
  import rsut_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_WUP   = 7'b0000100,
    S_QL    = 7'b0001000,
    S_QR    = 7'b0010000,
    S_QDONE = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

  state_t             state, state_next;
  logic [NODE_AW-1:0] k, k_next;
  logic [NODE_AW-1:0] k_up;
  logic [NODE_AW-1:0] leaf;
  logic [VAL_W-1:0]   cur, cur_next;
  logic [LR_W-1:0]    l, l_next;
  logic [LR_W-1:0]    r, r_next;
  logic [LR_W-1:0]    r_dec;
  logic [VAL_W-1:0]   acc, acc_next;
  logic               pend, pend_next;
  logic [NODE_AW-1:0] clr_cnt, clr_next;
  logic               out_free;
  logic               load_out;
  rsut_out_t          load_data;

  // node memory, one write and one registered read per cycle
  logic [VAL_W-1:0]   mem [TREE_NODES];
  logic               mem_we;
  logic [NODE_AW-1:0] mem_waddr;
  logic [NODE_AW-1:0] mem_raddr;
  logic [VAL_W-1:0]   mem_wdata;
  logic [VAL_W-1:0]   rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  assign busy     = state == S_CLEAR;
  assign out_free = !out_valid || out_ready;
  assign k_up     = k >> 1;
  assign leaf     = NODE_AW'(MAX_ELEMENTS) + NODE_AW'(q_data.idx_a);
  assign r_dec    = r - LR_W'(1);

  // sequencer
  always_comb begin
    state_next = state;
    k_next     = k;
    cur_next   = cur;
    l_next     = l;
    r_next     = r;
    pend_next  = 1'b0;
    clr_next   = clr_cnt;
    acc_next   = pend ? acc + rdata : acc;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = '0;
    pop        = 1'b0;
    load_out   = 1'b0;
    load_data  = '0;
    case (state)
      S_CLEAR: begin
        // zero every node after reset
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        clr_next  = clr_cnt + NODE_AW'(1);
        if (clr_cnt == NODE_AW'(TREE_NODES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          case (q_data.kind)
            CMD_WRITE: begin
              // store the leaf and fetch its sibling
              pop        = 1'b1;
              mem_we     = 1'b1;
              mem_waddr  = leaf;
              mem_wdata  = q_data.value;
              mem_raddr  = leaf ^ NODE_AW'(1);
              cur_next   = q_data.value;
              k_next     = leaf;
              state_next = S_WUP;
            end
            CMD_QUERY: begin
              pop        = 1'b1;
              l_next     = LR_W'(MAX_ELEMENTS) + LR_W'(q_data.idx_a);
              r_next     = LR_W'(MAX_ELEMENTS) + LR_W'(q_data.idx_b) + LR_W'(1);
              acc_next   = '0;
              state_next = S_QL;
            end
            CMD_EMPTY: begin
              if (out_free) begin
                pop                   = 1'b1;
                load_out              = 1'b1;
                load_data.range_total = '0;
                load_data.range_empty = 1'b1;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      S_WUP: begin
        // parent = node + sibling, then fetch the parent's sibling
        mem_we    = 1'b1;
        mem_waddr = k_up;
        mem_wdata = cur + rdata;
        mem_raddr = k_up ^ NODE_AW'(1);
        cur_next  = cur + rdata;
        k_next    = k_up;
        if (k_up == NODE_AW'(1)) begin
          state_next = S_IDLE;
        end
      end
      S_QL: begin
        // left edge of the level
        if (l < r) begin
          if (l[0]) begin
            mem_raddr = l[NODE_AW-1:0];
            pend_next = 1'b1;
            l_next    = l + LR_W'(1);
          end
          state_next = S_QR;
        end else begin
          state_next = S_QDONE;
        end
      end
      S_QR: begin
        // right edge of the level, then climb
        if (r[0]) begin
          mem_raddr = r_dec[NODE_AW-1:0];
          pend_next = 1'b1;
          r_next    = r_dec >> 1;
        end else begin
          r_next = r >> 1;
        end
        l_next     = l >> 1;
        state_next = S_QL;
      end
      S_QDONE: begin
        if (out_free) begin
          load_out              = 1'b1;
          load_data.range_total = $signed(acc);
          load_data.range_empty = 1'b0;
          state_next            = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      pend    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_next;
      pend    <= pend_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    k   <= k_next;
    cur <= cur_next;
    l   <= l_next;
    r   <= r_next;
    acc <= acc_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= load_data;
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_QDONE) |-> !pend)
    else $error("read sum still pending outside a query walk");
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == S_QR) |-> (l <= r))
    else $error("query left bound passed right bound");
  a_climb_above_root: assert property (@(posedge clk) disable iff (rst)
    (state == S_WUP) |-> (k > NODE_AW'(1)))
    else $error("update walk climbed past the root");

endmodule
